FILE: src/line_command_recognizer_top_defines.svh
// Assertion macros shared by the line command recognizer RTL.
`ifndef LINE_COMMAND_RECOGNIZER_TOP_DEFINES_SVH
`define LINE_COMMAND_RECOGNIZER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that a property holds at every clock edge outside reset.
`define LCR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Check that a condition never shows up outside reset.
`define LCR_ASSERT_NEVER(label, clk, rst_n, bad, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
        else $error(msg);
`else
`define LCR_ASSERT(label, clk, rst_n, prop, msg)
`define LCR_ASSERT_NEVER(label, clk, rst_n, bad, msg)
`endif
`endif

FILE: src/lcr_pkg.sv
package lcr_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int COUNT_W       = $clog2(LINE_CAPACITY);

    localparam int WORD_ON_LEN  = 6;
    localparam int WORD_OFF_LEN = 7;
    localparam int PREFIX_LEN   = 7;
    localparam int ON_IDX_W     = $clog2(WORD_ON_LEN);
    localparam int OFF_IDX_W    = $clog2(WORD_OFF_LEN);
    localparam int PREFIX_IDX_W = $clog2(PREFIX_LEN);

    localparam int LEVEL_MAX    = 100;
    localparam int LEVEL_W      = 7;
    localparam int KIND_W       = 2;
    localparam int CHAR_W       = 8;
    localparam int DECIMAL_BASE = 10;
    localparam int SUM_W        = LEVEL_W + 4;

    typedef logic [CHAR_W-1:0] char_t;

    localparam char_t CHAR_NUL   = 8'h00;
    localparam char_t CHAR_TAB   = 8'h09;
    localparam char_t CHAR_LF    = 8'h0A;
    localparam char_t CHAR_VT    = 8'h0B;
    localparam char_t CHAR_FF    = 8'h0C;
    localparam char_t CHAR_CR    = 8'h0D;
    localparam char_t CHAR_SPACE = 8'h20;
    localparam char_t CHAR_PLUS  = 8'h2B;
    localparam char_t CHAR_MINUS = 8'h2D;
    localparam char_t CHAR_ZERO  = 8'h30;
    localparam char_t CHAR_NINE  = 8'h39;

    localparam char_t WORD_ON [WORD_ON_LEN] = '{"L", "E", "D", "_", "O", "N"};
    localparam char_t WORD_OFF [WORD_OFF_LEN] = '{"L", "E", "D", "_", "O", "F", "F"};
    localparam char_t WORD_PREFIX [PREFIX_LEN] = '{"B", "R", "I", "G", "H", "T", "_"};

    typedef enum logic [KIND_W-1:0] {
        CMD_ON     = 2'd0,
        CMD_OFF    = 2'd1,
        CMD_BRIGHT = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } num_phase_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [LEVEL_W-1:0] level;
    } lcr_cmd_t;

endpackage

FILE: src/lcr_if.sv
interface rx_if import lcr_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface cmd_if import lcr_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  cmd_kind;
    logic [LEVEL_W-1:0] bright_level;

    modport source (output valid, output cmd_kind, output bright_level, input ready);
    modport sink (input valid, input cmd_kind, input bright_level, output ready);
endinterface

FILE: src/lcr_line.sv
`include "line_command_recognizer_top_defines.svh"

module lcr_line import lcr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  char_t    byte_in,
    output logic     hit,
    output lcr_cmd_t cmd_out
);

    logic [COUNT_W-1:0] char_count_reg, char_count_next;
    logic               on_match_reg, on_match_next;
    logic               off_match_reg, off_match_next;
    logic               prefix_match_reg, prefix_match_next;
    logic               text_ended_reg, text_ended_next;
    num_phase_t         number_phase_reg, number_phase_next;
    logic               number_negative_reg, number_negative_next;
    logic [LEVEL_W-1:0] number_magnitude_reg, number_magnitude_next;

    logic               is_term;
    logic               line_clear;
    logic               num_active;
    logic               on_final, off_final, prefix_final;
    logic               is_ws, is_sign, is_digit;
    logic [SUM_W-1:0]   mag_sum;

    assign is_term  = (byte_in == CHAR_CR) || (byte_in == CHAR_LF);
    assign is_ws    = (byte_in inside {CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF,
                                       CHAR_LF, CHAR_CR});
    assign is_sign  = (byte_in == CHAR_PLUS) || (byte_in == CHAR_MINUS);
    assign is_digit = (byte_in inside {[CHAR_ZERO:CHAR_NINE]});

    // Line end: the length check stands in for a NUL that never came.
    assign on_final     = on_match_reg &&
                          (text_ended_reg || char_count_reg == COUNT_W'(WORD_ON_LEN));
    assign off_final    = off_match_reg &&
                          (text_ended_reg || char_count_reg == COUNT_W'(WORD_OFF_LEN));
    assign prefix_final = prefix_match_reg &&
                          (text_ended_reg || char_count_reg >= COUNT_W'(PREFIX_LEN));

    // Byte past the prefix of a line still in the running for a level.
    assign num_active = step && !is_term && !text_ended_reg &&
                        (char_count_reg < COUNT_W'(LINE_CAPACITY - 1)) &&
                        (byte_in != CHAR_NUL) && prefix_match_reg &&
                        (char_count_reg >= COUNT_W'(PREFIX_LEN));

    always_comb
    begin
        char_count_next   = char_count_reg;
        on_match_next     = on_match_reg;
        off_match_next    = off_match_reg;
        prefix_match_next = prefix_match_reg;
        text_ended_next   = text_ended_reg;
        line_clear        = 1'b0;
        hit               = 1'b0;
        cmd_out           = '0;
        if (step)
        begin
            if (is_term)
            begin
                if (char_count_reg != '0)
                begin
                    line_clear = 1'b1;
                    hit        = on_final || off_final || prefix_final;
                    if (on_final)
                    begin
                        cmd_out.kind = CMD_ON;
                    end
                    else if (off_final)
                    begin
                        cmd_out.kind = CMD_OFF;
                    end
                    else if (prefix_final)
                    begin
                        cmd_out.kind  = CMD_BRIGHT;
                        cmd_out.level = number_negative_reg ? '0 : number_magnitude_reg;
                    end
                end
            end
            else if (char_count_reg < COUNT_W'(LINE_CAPACITY - 1))
            begin
                char_count_next = char_count_reg + 1'b1;
                if (!text_ended_reg)
                begin
                    if (byte_in == CHAR_NUL)
                    begin
                        text_ended_next   = 1'b1;
                        on_match_next     = on_match_reg &&
                                            (char_count_reg == COUNT_W'(WORD_ON_LEN));
                        off_match_next    = off_match_reg &&
                                            (char_count_reg == COUNT_W'(WORD_OFF_LEN));
                        prefix_match_next = prefix_match_reg &&
                                            (char_count_reg >= COUNT_W'(PREFIX_LEN));
                    end
                    else
                    begin
                        on_match_next  = on_match_reg &&
                            (char_count_reg < COUNT_W'(WORD_ON_LEN)) &&
                            (byte_in == WORD_ON[char_count_reg[ON_IDX_W-1:0]]);
                        off_match_next = off_match_reg &&
                            (char_count_reg < COUNT_W'(WORD_OFF_LEN)) &&
                            (byte_in == WORD_OFF[char_count_reg[OFF_IDX_W-1:0]]);
                        if (char_count_reg < COUNT_W'(PREFIX_LEN))
                        begin
                            prefix_match_next = prefix_match_reg &&
                                (byte_in == WORD_PREFIX[char_count_reg[PREFIX_IDX_W-1:0]]);
                        end
                    end
                end
            end
            else
            begin
                // Overlong line: drop the byte and start over.
                line_clear = 1'b1;
            end
        end
        if (line_clear)
        begin
            char_count_next   = '0;
            on_match_next     = 1'b1;
            off_match_next    = 1'b1;
            prefix_match_next = 1'b1;
            text_ended_next   = 1'b0;
        end
    end

    // Number parser: next phase.
    always_comb
    begin
        number_phase_next = number_phase_reg;
        if (line_clear)
        begin
            number_phase_next = PH_SKIP;
        end
        else if (num_active)
        begin
            case (number_phase_reg)
                PH_SKIP:
                begin
                    if (is_ws)
                    begin
                        number_phase_next = PH_SKIP;
                    end
                    else if (is_sign)
                    begin
                        number_phase_next = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        number_phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        number_phase_next = PH_DONE;
                    end
                end
                PH_SIGN, PH_DIGITS:
                begin
                    number_phase_next = is_digit ? PH_DIGITS : PH_DONE;
                end
                default:
                begin
                    number_phase_next = PH_DONE;
                end
            endcase
        end
    end

    // Number parser: sign and saturating magnitude.
    assign mag_sum = SUM_W'(number_magnitude_reg) * SUM_W'(DECIMAL_BASE) +
                     SUM_W'(byte_in - CHAR_ZERO);

    always_comb
    begin
        number_negative_next  = number_negative_reg;
        number_magnitude_next = number_magnitude_reg;
        if (line_clear)
        begin
            number_negative_next  = 1'b0;
            number_magnitude_next = '0;
        end
        else if (num_active)
        begin
            case (number_phase_reg)
                PH_SKIP:
                begin
                    if (!is_ws && is_sign)
                    begin
                        number_negative_next = (byte_in == CHAR_MINUS);
                    end
                    else if (!is_ws && is_digit)
                    begin
                        number_magnitude_next = (mag_sum > SUM_W'(LEVEL_MAX)) ?
                            LEVEL_W'(LEVEL_MAX) : mag_sum[LEVEL_W-1:0];
                    end
                end
                PH_SIGN, PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        number_magnitude_next = (mag_sum > SUM_W'(LEVEL_MAX)) ?
                            LEVEL_W'(LEVEL_MAX) : mag_sum[LEVEL_W-1:0];
                    end
                end
                default:
                begin
                    number_magnitude_next = number_magnitude_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg       <= '0;
            on_match_reg         <= 1'b1;
            off_match_reg        <= 1'b1;
            prefix_match_reg     <= 1'b1;
            text_ended_reg       <= 1'b0;
            number_phase_reg     <= PH_SKIP;
            number_negative_reg  <= 1'b0;
            number_magnitude_reg <= '0;
        end
        else
        begin
            char_count_reg       <= char_count_next;
            on_match_reg         <= on_match_next;
            off_match_reg        <= off_match_next;
            prefix_match_reg     <= prefix_match_next;
            text_ended_reg       <= text_ended_next;
            number_phase_reg     <= number_phase_next;
            number_negative_reg  <= number_negative_next;
            number_magnitude_reg <= number_magnitude_next;
        end
    end

    `LCR_ASSERT(a_count_range, clk, rst_n, char_count_reg <= COUNT_W'(LINE_CAPACITY - 1), "line count past capacity")
    `LCR_ASSERT(a_mag_sat, clk, rst_n, number_magnitude_reg <= LEVEL_W'(LEVEL_MAX), "magnitude not saturated")
    `LCR_ASSERT(a_phase_prefix, clk, rst_n, (number_phase_reg != PH_SKIP) |-> (prefix_match_reg && char_count_reg > COUNT_W'(PREFIX_LEN)), "number parsed outside a prefixed line")

endmodule

FILE: src/lcr_out_reg.sv
module lcr_out_reg import lcr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  logic     hit,
    input  lcr_cmd_t cmd_in,
    output logic     free,
    cmd_if.source    cmd
);

    logic     valid_reg, valid_next;
    lcr_cmd_t cmd_reg;

    assign free = !valid_reg || cmd.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = hit;
        end
        else if (cmd.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && hit)
        begin
            cmd_reg <= cmd_in;
        end
    end

    assign cmd.valid        = valid_reg;
    assign cmd.cmd_kind     = cmd_reg.kind;
    assign cmd.bright_level = cmd_reg.level;

endmodule

FILE: src/line_command_recognizer_top.sv
// A byte that ends a command line passes the input register, then the result register, to cmd.
// One byte per cycle unless cmd stalls; the input and result registers each hold one word.
// The line state update per byte includes a multiply-add by ten on the 7-bit magnitude.
// Reset (rst_n low, asynchronous) empties both registers and clears the line state.
// After reset the block is ready at once; no clearing pass is needed.
`include "line_command_recognizer_top_defines.svh"

module line_command_recognizer_top import lcr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    rx_if.sink    rx,
    cmd_if.source cmd
);

    // Input register: holds one received byte ahead of the line logic.
    logic     s1_valid_reg, s1_valid_next;
    char_t    s1_byte_reg;

    // Handshake between the stages.
    logic     out_free;
    logic     advance;
    logic     in_take;

    // Result of judging the byte held in the input register.
    logic     line_hit;
    lcr_cmd_t line_cmd;

    // The byte in the input register moves on whenever the result register
    // can take whatever it produces; an open result slot or a taken result
    // both count, so a new byte enters in the same cycle a result leaves.
    assign advance  = s1_valid_reg && out_free;
    assign rx.ready = !s1_valid_reg || out_free;
    assign in_take  = rx.valid && rx.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture the payload only on a take; otherwise hold it.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= rx.rx_byte;
        end
    end

    // Line tracker: match flags, length count and the number parser. It
    // advances its state once per byte that leaves the input register.
    lcr_line u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (s1_byte_reg),
        .hit     (line_hit),
        .cmd_out (line_cmd)
    );

    // Result register: loads with each advancing byte; only a line that
    // matched a command raises valid, the rest leave the slot empty.
    lcr_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .hit    (line_hit),
        .cmd_in (line_cmd),
        .free   (out_free),
        .cmd    (cmd)
    );

    `LCR_ASSERT(a_s1_hold, clk, rst_n, (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_byte_reg)), "input word lost under stall")
    `LCR_ASSERT_NEVER(a_level_kind, clk, rst_n, cmd.valid && (cmd.cmd_kind != CMD_BRIGHT) && (cmd.bright_level != '0), "level set on a light command")
    `LCR_ASSERT_NEVER(a_level_range, clk, rst_n, cmd.valid && (cmd.bright_level > LEVEL_W'(LEVEL_MAX)), "level above maximum")

endmodule
